// ===== rtl/hnfd_pkg.sv =====
`timescale 1ns / 1ps
package hnfd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned CFG_ADDR_W      = 4;

  localparam logic [7:0] START_BYTE_RST   = 8'hf7;
  localparam logic [7:0] THERMAL_CODE_RST = 8'h36;
  localparam logic [7:0] VENT_CODE_RST    = 8'h32;

  typedef enum logic [1:0] {
    REG_START   = 2'd0,
    REG_THERMAL = 2'd1,
    REG_VENT    = 2'd2
  } hnfd_reg_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_DEVICE,
    PH_SUB,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_XOR,
    PH_SUM
  } hnfd_phase_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_XOR_BAD = 2'd1,
    STAT_SUM_BAD = 2'd2
  } hnfd_status_t;

  localparam logic EV_DATA  = 1'b0;
  localparam logic EV_FRAME = 1'b1;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] thermal_code;
    logic [7:0] vent_code;
  } hnfd_cfg_t;

  typedef struct packed {
    logic         event_kind;
    logic [7:0]   data_byte;
    logic         device_kind;
    logic [7:0]   sub_id;
    logic [7:0]   command_code;
    logic [7:0]   data_length;
    hnfd_status_t status;
  } hnfd_item_t;

endpackage

// ===== rtl/hnfd_parser.sv =====
`timescale 1ns / 1ps
module hnfd_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hnfd_pkg::hnfd_cfg_t    cfg,
  input  logic                   byte_valid,
  input  logic [7:0]             rx_byte,
  output logic                   item_valid,
  output hnfd_pkg::hnfd_item_t   item
);
  import hnfd_pkg::*;

  hnfd_phase_t phase_r, phase_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        dev_r, dev_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic        xok_r, xok_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
      len_r   <= '0;
      xor_r   <= '0;
      sum_r   <= '0;
      dev_r   <= 1'b0;
      sub_r   <= '0;
      cmd_r   <= '0;
      xok_r   <= 1'b0;
    end else if (byte_valid) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      sum_r   <= sum_nxt;
      dev_r   <= dev_nxt;
      sub_r   <= sub_nxt;
      cmd_r   <= cmd_nxt;
      xok_r   <= xok_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    xor_nxt    = xor_r ^ rx_byte;
    sum_nxt    = sum_r + rx_byte;
    dev_nxt    = dev_r;
    sub_nxt    = sub_r;
    cmd_nxt    = cmd_r;
    xok_nxt    = xok_r;
    item_valid = 1'b0;
    item.event_kind   = EV_DATA;
    item.data_byte    = rx_byte;
    item.device_kind  = dev_r;
    item.sub_id       = sub_r;
    item.command_code = cmd_r;
    item.data_length  = len_r;
    item.status       = STAT_OK;
    unique case (phase_r)
      PH_HUNT: begin
        xor_nxt = xor_r;
        sum_nxt = sum_r;
        if (rx_byte == cfg.start_byte) begin
          xor_nxt   = rx_byte;
          sum_nxt   = rx_byte;
          phase_nxt = PH_DEVICE;
        end
      end
      PH_DEVICE: begin
        phase_nxt = PH_SUB;
        // thermal wins when both codes match
        if (rx_byte == cfg.thermal_code) begin
          dev_nxt = 1'b0;
        end else if (rx_byte == cfg.vent_code) begin
          dev_nxt = 1'b1;
        end else begin
          xor_nxt   = xor_r;
          sum_nxt   = sum_r;
          phase_nxt = PH_HUNT;
        end
      end
      PH_SUB: begin
        sub_nxt   = rx_byte;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt   = rx_byte;
        count_nxt = '0;
        phase_nxt = (rx_byte == 8'd0) ? PH_XOR : PH_DATA;
      end
      PH_DATA: begin
        count_nxt  = count_r + 8'd1;
        if (count_nxt == len_r) phase_nxt = PH_XOR;
        item_valid = 1'b1;
      end
      PH_XOR: begin
        xok_nxt   = (rx_byte == xor_r);
        phase_nxt = PH_SUM;
      end
      PH_SUM: begin
        phase_nxt       = PH_HUNT;
        item_valid      = 1'b1;
        item.event_kind = EV_FRAME;
        if (!xok_r) item.status = STAT_XOR_BAD;
        else if (rx_byte != sum_r) item.status = STAT_SUM_BAD;
        else item.status = STAT_OK;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

endmodule

// ===== rtl/hnfd_queue.sv =====
`timescale 1ns / 1ps
module hnfd_queue #(
  parameter int unsigned DEPTH = hnfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  hnfd_pkg::hnfd_item_t wr_item,
  output logic                 full,
  input  logic                 rd_en,
  output hnfd_pkg::hnfd_item_t rd_item,
  output logic                 empty
);
  import hnfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hnfd_item_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + PTR_W'(1);
      if (do_rd) rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + PTR_W'(1);
      if (do_wr && !do_rd) cnt_r <= cnt_r + CNT_W'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/hnfd_emitter.sv =====
`timescale 1ns / 1ps
module hnfd_emitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  hnfd_pkg::hnfd_item_t q_item,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_event_kind,
  output logic [7:0]           out_payload_byte,
  output logic                 out_device_kind,
  output logic [7:0]           out_sub_id,
  output logic [7:0]           out_command_code,
  output logic [7:0]           out_data_length,
  output logic [1:0]           out_frame_status,
  output logic                 out_is_request
);
  import hnfd_pkg::*;

  logic       valid_r;
  logic       kind_r;
  logic [7:0] payload_r;
  logic       dev_r;
  logic [7:0] sub_r, cmd_r, len_r;
  logic [1:0] status_r;
  logic       req_r;

  // refill whenever the held result is gone or leaves this cycle
  assign q_pop = !q_empty && (!valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r    <= q_item.event_kind;
      payload_r <= (q_item.event_kind == EV_FRAME) ? 8'd0 : q_item.data_byte;
      dev_r     <= q_item.device_kind;
      sub_r     <= q_item.sub_id;
      cmd_r     <= q_item.command_code;
      len_r     <= q_item.data_length;
      status_r  <= (q_item.event_kind == EV_FRAME) ? q_item.status : STAT_OK;
      req_r     <= (q_item.event_kind == EV_FRAME) && (q_item.status == STAT_OK)
                   && !q_item.command_code[7];
    end
  end

  assign out_empty        = !valid_r;
  assign out_event_kind   = kind_r;
  assign out_payload_byte = payload_r;
  assign out_device_kind  = dev_r;
  assign out_sub_id       = sub_r;
  assign out_command_code = cmd_r;
  assign out_data_length  = len_r;
  assign out_frame_status = status_r;
  assign out_is_request   = req_r;

endmodule

// ===== rtl/home_net_frame_deframer.sv =====
`timescale 1ns / 1ps
// Receive-side frame parser: one serial byte per transfer on the in_ side,
// a frame being start, device code, sub id, command, length, data bytes,
// XOR byte and sum byte. Each data byte gives one result (event_kind 0)
// and the sum byte gives one frame result (event_kind 1) with the header
// and check status; all other bytes give none. A byte is taken every cycle
// while in_full is low: the parser does one phase step with an 8-bit XOR
// and add per byte, and its results go through a QUEUE_DEPTH-entry queue
// into an output register, so a result reaches out_ via a queue slot and
// that register; in_full rises only when the queue is full. The three
// registers (start byte at 0x0, thermal code at 0x4, vent code at 0x8)
// must be written via cfg_ only while the block is idle (not enforced).
module home_net_frame_deframer #(
  parameter int unsigned QUEUE_DEPTH = hnfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hnfd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_event_kind,
  output logic [7:0]                      out_payload_byte,
  output logic                            out_device_kind,
  output logic [7:0]                      out_sub_id,
  output logic [7:0]                      out_command_code,
  output logic [7:0]                      out_data_length,
  output logic [1:0]                      out_frame_status,
  output logic                            out_is_request
);
  import hnfd_pkg::*;

  hnfd_cfg_t  cfg_r;
  hnfd_reg_t  reg_sel;
  logic       cfg_wr;
  logic       byte_acc;
  logic       front_valid;
  hnfd_item_t front_item;
  logic       q_full, q_empty, q_pop;
  hnfd_item_t q_item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  // word decode: the byte lanes of the address are not looked at
  assign reg_sel    = hnfd_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte   <= START_BYTE_RST;
      cfg_r.thermal_code <= THERMAL_CODE_RST;
      cfg_r.vent_code    <= VENT_CODE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_START:   cfg_r.start_byte   <= cfg_pwdata[7:0];
        REG_THERMAL: cfg_r.thermal_code <= cfg_pwdata[7:0];
        REG_VENT:    cfg_r.vent_code    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_sel)
      REG_START:   cfg_prdata = {24'd0, cfg_r.start_byte};
      REG_THERMAL: cfg_prdata = {24'd0, cfg_r.thermal_code};
      REG_VENT:    cfg_prdata = {24'd0, cfg_r.vent_code};
      default:     cfg_prdata = '0;
    endcase
  end

  assign in_full  = q_full;
  assign byte_acc = in_push && !q_full;

  hnfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (byte_acc),
    .rx_byte    (in_rx_byte),
    .item_valid (front_valid),
    .item       (front_item)
  );

  hnfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (byte_acc && front_valid),
    .wr_item (front_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  hnfd_emitter u_emitter (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_event_kind   (out_event_kind),
    .out_payload_byte (out_payload_byte),
    .out_device_kind  (out_device_kind),
    .out_sub_id       (out_sub_id),
    .out_command_code (out_command_code),
    .out_data_length  (out_data_length),
    .out_frame_status (out_frame_status),
    .out_is_request   (out_is_request)
  );

endmodule
